// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the rational approximation RTL.
// Every use expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BRA_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bra_pkg.sv =====
// Package for the best rational approximation block.
// Holds the sequencer state type, divider status and fixed constants; no dependencies.
`timescale 1ns / 1ps

package bra_pkg;

  // Reset value of the maximum denominator register.
  localparam logic [15:0] MAX_DEN_RESET = 16'd2047;

  // Sequencer states of the approximation engine.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHK,
    ST_UPD_D,
    ST_UPD_N,
    ST_FDIV,
    ST_FM1,
    ST_FM2,
    ST_FM3,
    ST_FE1,
    ST_FE2,
    ST_FX1,
    ST_FX2,
    ST_FX3
  } bra_state_e;

  // Status of the iterative divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hdl/bra_div.sv =====
// Restoring divider that yields one quotient bit per cycle.
// Depends on bra_pkg for its status type and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bra_div #(
  parameter int DW = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DW-1:0]      dividend_i,
  input  logic [DW-1:0]      divisor_i,
  output bra_pkg::div_stat_t stat_o,
  output logic [DW-1:0]      quotient_o,
  output logic [DW-1:0]      remainder_o
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [DW-1:0] rem_q, quo_q, dsr_q;
  logic [DW:0]   shifted;
  logic          fits;
  logic [DW:0]   diff;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign shifted = {rem_q, quo_q[DW-1]};
  assign fits    = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  // Step counter and completion pulse.
  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d = CW'(DW);
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Partial remainder, quotient shift register and divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign stat_o.busy  = (cnt_q != '0);
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

  // A finished division leaves a remainder below a nonzero divisor.
  `BRA_ASSERT_IMM(a_rem_below_dsr, done_q, (dsr_q == '0) || (rem_q < dsr_q), "remainder too large")
  // The done pulse follows the last step and never stretches.
  `BRA_ASSERT_NXT(a_done_single, done_q && !start_i, !done_q && (cnt_q == '0), "done not single")

endmodule

// ===== hdl/best_rational_approximation_top.sv =====
// Top level of the best rational approximation block: sequencer, shared multiplier.
// Depends on bra_pkg, bra_div and assert_macros.svh.
//
//   channel   ports                                  handshake
//   --------  -------------------------------------  -------------------------
//   request   start, busy, x_fraction_i               taken when start && !busy
//   result    result_valid_o, numerator_o,           one-cycle strobe, no stall
//             denominator_o
//   config    cfg_we_i, cfg_wdata_i (max_den)        written when cfg_we_i
//
// The leading term needs no division. Every later term runs a DW-step bit-serial division
// (DW = FRAC_BITS+1, at least 16), then the check state and the two update states. The
// closing semiconvergent runs one more division, then the multiply, error and compare
// states. The result strobe lasts one cycle and the next request may start in that same
// cycle. Reset clears the sequencer and sets max_den to 2047.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module best_rational_approximation_top #(
  parameter int FRAC_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_fraction_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [15:0] numerator_o,
  output logic [15:0] denominator_o
);

  localparam int DW = (FRAC_BITS + 1 > 16) ? FRAC_BITS + 1 : 16;
  localparam int AW = FRAC_BITS + 16;
  localparam int PW = FRAC_BITS + 32;
  localparam int XB = (FRAC_BITS < 32) ? FRAC_BITS : 32;

  bra_pkg::bra_state_e state_q, state_d;
  logic                valid_q, valid_d;
  logic [15:0]         max_den_q;

  logic [FRAC_BITS-1:0] xv_in, xv_q;
  logic [DW-1:0]        one_dw;
  logic [15:0]          lim_q;
  logic [15:0]          n0_q, n1_q, d0_q, d1_q, n2_q, d2_q;
  logic [DW-1:0]        a_q, q_q, r_q;
  logic [AW-1:0]        e1_q, e2_q;
  logic [PW-1:0]        lhs_q, mul_q;
  logic [15:0]          numerator_q, denominator_q;

  logic [AW-1:0]        mul_a;
  logic [15:0]          mul_b;
  logic                 div_start;
  logic [DW-1:0]        div_dividend, div_divisor;
  bra_pkg::div_stat_t   div_stat;
  logic [DW-1:0]        div_quo, div_rem;

  logic                 accept;
  logic                 chk_pass;
  logic                 r_zero;
  logic [15:0]          mul_lo;
  logic [PW-1:0]        err_ref;
  logic [PW-1:0]        err_abs;
  logic                 take_semi;

  // Input value reduced to FRAC_BITS fraction bits, and the fixed-point one.
  assign xv_in  = FRAC_BITS'(x_fraction_i[XB-1:0]);
  assign one_dw = DW'(1) << FRAC_BITS;
  assign accept = start && !busy;

  // Term check: the next denominator d1*a + d0 must stay within the limit.
  assign chk_pass = (d0_q <= lim_q) && ((mul_q + PW'(d0_q)) <= PW'(lim_q));
  assign r_zero   = (r_q == '0);
  assign mul_lo   = mul_q[15:0];

  // Absolute error numerators |x*d - n*2^FRAC_BITS| for the two candidates.
  assign err_ref = (state_q == bra_pkg::ST_FE1) ? (PW'(n1_q) << FRAC_BITS)
                                                : (PW'(n2_q) << FRAC_BITS);
  assign err_abs = (mul_q >= err_ref) ? (mul_q - err_ref) : (err_ref - mul_q);

  // Keep the semiconvergent only if its cross-multiplied error is smaller.
  assign take_semi = (d2_q != '0) && (lhs_q < mul_q);

  // Shared iterative divider for every Euclid quotient and the final term.
  bra_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo),
    .remainder_o(div_rem)
  );

  // Sequencer: next state, divider launch and multiplier operand selection.
  always_comb begin
    state_d      = state_q;
    valid_d      = 1'b0;
    div_start    = 1'b0;
    div_dividend = q_q;
    div_divisor  = r_q;
    mul_a        = AW'(a_q);
    mul_b        = d1_q;
    case (state_q)
      bra_pkg::ST_IDLE: begin
        if (start) begin
          state_d = bra_pkg::ST_CHK;
        end
      end
      bra_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_d = bra_pkg::ST_CHK;
        end
      end
      bra_pkg::ST_CHK: begin
        state_d = bra_pkg::ST_UPD_D;
      end
      bra_pkg::ST_UPD_D: begin
        mul_b = n1_q;
        if (chk_pass) begin
          state_d = bra_pkg::ST_UPD_N;
        end else begin
          div_start    = 1'b1;
          div_dividend = DW'(lim_q - d0_q);
          div_divisor  = DW'(d1_q);
          state_d      = bra_pkg::ST_FDIV;
        end
      end
      bra_pkg::ST_UPD_N: begin
        div_start = 1'b1;
        if (r_zero) begin
          div_dividend = DW'(lim_q - d0_q);
          div_divisor  = DW'(d1_q);
          state_d      = bra_pkg::ST_FDIV;
        end else begin
          state_d = bra_pkg::ST_DIV;
        end
      end
      bra_pkg::ST_FDIV: begin
        if (div_stat.done) begin
          state_d = bra_pkg::ST_FM1;
        end
      end
      bra_pkg::ST_FM1: begin
        state_d = bra_pkg::ST_FM2;
      end
      bra_pkg::ST_FM2: begin
        mul_b   = n1_q;
        state_d = bra_pkg::ST_FM3;
      end
      bra_pkg::ST_FM3: begin
        mul_a   = AW'(xv_q);
        state_d = bra_pkg::ST_FE1;
      end
      bra_pkg::ST_FE1: begin
        mul_a   = AW'(xv_q);
        mul_b   = d2_q;
        state_d = bra_pkg::ST_FE2;
      end
      bra_pkg::ST_FE2: begin
        state_d = bra_pkg::ST_FX1;
      end
      bra_pkg::ST_FX1: begin
        mul_a   = e2_q;
        state_d = bra_pkg::ST_FX2;
      end
      bra_pkg::ST_FX2: begin
        mul_a   = e1_q;
        mul_b   = d2_q;
        state_d = bra_pkg::ST_FX3;
      end
      bra_pkg::ST_FX3: begin
        valid_d = 1'b1;
        state_d = bra_pkg::ST_IDLE;
      end
      default: begin
        state_d = bra_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bra_pkg::ST_IDLE;
      valid_q   <= 1'b0;
      max_den_q <= bra_pkg::MAX_DEN_RESET;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        max_den_q <= cfg_wdata_i;
      end
    end
  end

  // Shared multiplier with its registered product.
  always_ff @(posedge clk_i) begin
    mul_q <= PW'(mul_a) * PW'(mul_b);
  end

  // Convergent recurrences, Euclid operands and error terms.
  always_ff @(posedge clk_i) begin
    case (state_q)
      bra_pkg::ST_IDLE: begin
        if (start) begin
          xv_q  <= xv_in;
          lim_q <= (max_den_q == '0) ? 16'd1 : max_den_q;
          q_q   <= one_dw;
          // Since x < 1 the leading term is zero and x itself is the remainder.
          a_q   <= '0;
          r_q   <= DW'(xv_in);
          n1_q  <= 16'd1;
          n0_q  <= 16'd0;
          d1_q  <= 16'd0;
          d0_q  <= 16'd1;
        end
      end
      bra_pkg::ST_DIV: begin
        if (div_stat.done) begin
          a_q <= div_quo;
          r_q <= div_rem;
        end
      end
      bra_pkg::ST_UPD_D: begin
        if (chk_pass) begin
          d0_q <= d1_q;
          d1_q <= mul_lo + d0_q;
        end
      end
      bra_pkg::ST_UPD_N: begin
        n0_q <= n1_q;
        n1_q <= mul_lo + n0_q;
        if (!r_zero) begin
          q_q <= r_q;
        end
      end
      bra_pkg::ST_FDIV: begin
        if (div_stat.done) begin
          a_q <= div_quo;
        end
      end
      bra_pkg::ST_FM2: begin
        d2_q <= mul_lo + d0_q;
      end
      bra_pkg::ST_FM3: begin
        n2_q <= mul_lo + n0_q;
      end
      bra_pkg::ST_FE1: begin
        e1_q <= AW'(err_abs);
      end
      bra_pkg::ST_FE2: begin
        e2_q <= AW'(err_abs);
      end
      bra_pkg::ST_FX2: begin
        lhs_q <= mul_q;
      end
      bra_pkg::ST_FX3: begin
        numerator_q   <= take_semi ? n2_q : n1_q;
        denominator_q <= take_semi ? d2_q : d1_q;
      end
      default: begin
      end
    endcase
  end

  assign busy           = (state_q != bra_pkg::ST_IDLE);
  assign result_valid_o = valid_q;
  assign numerator_o    = numerator_q;
  assign denominator_o  = denominator_q;

  // The divider is only launched when it is free.
  `BRA_ASSERT_IMM(a_div_free, div_start, !div_stat.busy, "divider started while busy")
  // A result strobe is a single-cycle pulse.
  `BRA_ASSERT_NXT(a_strobe_pulse, valid_q, !valid_q, "result strobe held")
  // A delivered result has a legal denominator and a fraction not above one.
  `BRA_ASSERT_IMM(a_result_range, valid_q, (denominator_q != '0) && (denominator_q <= lim_q) && (numerator_q <= denominator_q), "result out of range")
  // An accepted request makes the block busy on the next cycle.
  `BRA_ASSERT_NXT(a_accept_busy, accept, busy && !valid_q, "request not taken")

endmodule

// ===== sim/tb_best_rational_approximation_top.sv =====
// Self-checking testbench for best_rational_approximation_top: directed table, then random requests.
// Depends on bra_pkg and the RTL under hdl; results are checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_best_rational_approximation_top;

  localparam int FRAC_W         = 32;
  localparam int MAX_TERMS      = 96;
  localparam int N_DIRECTED     = 24;
  localparam int N_PHASES       = 6;
  localparam int PHASE_REQS     = 100;
  localparam int DRAIN_CYCLES   = 5000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int REPORT_LIMIT   = 10;
  localparam int IDLE_NONE      = 0;
  localparam int IDLE_SENDER    = 56;
  localparam int IDLE_BOTH      = 23;
  localparam logic [15:0] DEN_ZERO = 16'd0;
  localparam logic [15:0] DEN_ONE  = 16'd1;
  localparam logic [15:0] DEN_TOP  = 16'hFFFF;

  // One row of the directed table; the typed flag says whether num/den are given.
  typedef struct packed {
    logic [15:0] max_den;
    logic [31:0] x;
    logic        typed;
    logic [15:0] num;
    logic [15:0] den;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] num;
    logic [15:0] den;
  } fraction_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] x_fraction_i;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        result_valid_o;
  logic [15:0] numerator_o;
  logic [15:0] denominator_o;

  fraction_t   awaited_fracs[$];
  logic [15:0] max_den_shadow;
  int          idle_pct;
  int          fail_count;
  int          report_count;
  dir_row_t    directed_rows [N_DIRECTED];

  best_rational_approximation_top #(
    .FRAC_BITS(FRAC_W)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .x_fraction_i  (x_fraction_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .numerator_o   (numerator_o),
    .denominator_o (denominator_o)
  );

  // Free-running clock, 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Best approximation by continued-fraction convergents plus one final semiconvergent.
  function automatic fraction_t best_fraction(input logic [31:0] x, input logic [15:0] den_cap);
    logic [63:0]  one_q, xv, lim, p, q, a, r, t;
    logic [63:0]  n_cur, n_prev, d_cur, d_prev, n_semi, d_semi, err_cv, err_semi;
    logic [127:0] lhs, rhs;
    logic         stop;
    int           terms;
    fraction_t    res;
    one_q  = 64'd1 << FRAC_W;
    xv     = {32'd0, x} & (one_q - 64'd1);
    lim    = (den_cap == DEN_ZERO) ? 64'd1 : {48'd0, den_cap};
    p      = xv;
    q      = one_q;
    n_cur  = 64'd1;
    n_prev = 64'd0;
    d_cur  = 64'd0;
    d_prev = 64'd1;
    stop   = 1'b0;
    terms  = 0;
    // Euclid steps until the next denominator would pass the cap or the remainder vanishes.
    while (!stop && terms < MAX_TERMS) begin
      a = p / q;
      if (d_cur == 64'd0) stop = (d_prev > lim);
      else stop = (d_prev > lim) || (a > (lim - d_prev) / d_cur);
      if (!stop) begin
        t = n_cur * a + n_prev;
        n_prev = n_cur;
        n_cur = t;
        t = d_cur * a + d_prev;
        d_prev = d_cur;
        d_cur = t;
        r = p % q;
        if (r == 64'd0) begin
          stop = 1'b1;
        end else begin
          p = q;
          q = r;
        end
      end
      terms++;
    end
    if (d_cur == 64'd0) d_cur = 64'd1;
    // Semiconvergent with the largest term that still fits under the cap.
    a      = (lim - d_prev) / d_cur;
    n_semi = n_cur * a + n_prev;
    d_semi = d_cur * a + d_prev;
    err_cv   = (xv * d_cur >= n_cur * one_q) ? xv * d_cur - n_cur * one_q
                                             : n_cur * one_q - xv * d_cur;
    err_semi = (xv * d_semi >= n_semi * one_q) ? xv * d_semi - n_semi * one_q
                                               : n_semi * one_q - xv * d_semi;
    lhs = 128'(err_semi) * 128'(d_cur);
    rhs = 128'(err_cv) * 128'(d_semi);
    if (d_semi != 64'd0 && lhs < rhs) begin
      n_cur = n_semi;
      d_cur = d_semi;
    end
    res.num = n_cur[15:0];
    res.den = d_cur[15:0];
    return res;
  endfunction

  // Random fraction: uniform, near a small rational, tiny, close to one, or an exact rational.
  function automatic logic [31:0] pick_fraction();
    int unsigned mode;
    logic [63:0] n, d, v;
    mode = $urandom_range(99);
    if (mode < 40) return $urandom;
    if (mode < 70 || mode >= 90) begin
      d = 64'($urandom_range(1, ($urandom_range(3) == 0) ? 70000 : 64));
      n = 64'($urandom_range(0, 32'(d - 64'd1)));
      v = (n << FRAC_W) / d;
      if (mode < 70) begin
        if ($urandom_range(1) == 1) v = v + 64'($urandom_range(15));
        else v = v - 64'($urandom_range(15));
      end
      return v[31:0];
    end
    if (mode < 80) return $urandom >> $urandom_range(31);
    return ~($urandom >> $urandom_range(31));
  endfunction

  task automatic note_failure(input string what, input fraction_t want);
    fail_count++;
    if (report_count < REPORT_LIMIT) begin
      report_count++;
      $display("%0t: %s: expected %0d/%0d, got %0d/%0d", $realtime, what,
               want.num, want.den, numerator_o, denominator_o);
    end
  endtask

  // Result checker: every strobe must match the oldest outstanding expectation.
  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni && result_valid_o) begin
      if (awaited_fracs.size() == 0) begin
        want = '0;
        note_failure("result with no request pending", want);
      end else begin
        want = awaited_fracs.pop_front();
        if (numerator_o !== want.num || denominator_o !== want.den)
          note_failure("result mismatch", want);
      end
    end
  end

  // Issue one request, optionally idling until the block is free plus a few cycles.
  task automatic send_request(input logic [31:0] x, input logic typed, input fraction_t given);
    if (idle_pct != IDLE_NONE && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      x_fraction_i <= $urandom;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      repeat ($urandom_range(3)) @(posedge clk_i);
    end
    start <= 1'b1;
    x_fraction_i <= x;
    do @(posedge clk_i); while (busy);
    if (typed) awaited_fracs.push_back(given);
    else awaited_fracs.push_back(best_fraction(x, max_den_shadow));
  endtask

  // Register write, done only once every result is back and the block is idle.
  task automatic write_max_den(input logic [15:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited_fracs.size() != 0 || busy) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    max_den_shadow = value;
  endtask

  // Watchdog.
  initial begin
    #60ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    fraction_t   given;
    logic [15:0] phase_den;
    int          waited;
    rst_ni         = 1'b0;
    start          <= 1'b0;
    x_fraction_i   <= '0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    fail_count     = 0;
    report_count   = 0;
    idle_pct       = IDLE_NONE;
    max_den_shadow = bra_pkg::MAX_DEN_RESET;

    // max_den, x, typed, num, den
    directed_rows = '{
      '{16'd2047,  32'h0000_0000, 1'b1, 16'd0, 16'd1},
      '{16'd2047,  32'h8000_0000, 1'b1, 16'd1, 16'd2},
      '{16'd2047,  32'h4000_0000, 1'b1, 16'd1, 16'd4},
      '{16'd2047,  32'hC000_0000, 1'b1, 16'd3, 16'd4},
      '{16'd2047,  32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0},
      '{16'd2047,  32'h0000_0001, 1'b0, 16'd0, 16'd0},
      '{16'd2047,  32'h5555_5555, 1'b0, 16'd0, 16'd0},
      '{16'd2047,  32'h243F_6A88, 1'b0, 16'd0, 16'd0},
      '{16'd2047,  32'h9E37_79B9, 1'b0, 16'd0, 16'd0},
      '{DEN_TOP,   32'h0000_0000, 1'b1, 16'd0, 16'd1},
      '{DEN_TOP,   32'h9E37_79B9, 1'b0, 16'd0, 16'd0},
      '{DEN_TOP,   32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0},
      '{DEN_TOP,   32'h0000_0001, 1'b0, 16'd0, 16'd0},
      '{DEN_TOP,   32'h0001_0000, 1'b0, 16'd0, 16'd0},
      '{DEN_TOP,   32'h7FFF_FFFF, 1'b0, 16'd0, 16'd0},
      '{DEN_TOP,   32'hAAAA_AAAA, 1'b0, 16'd0, 16'd0},
      '{DEN_ONE,   32'h0000_0000, 1'b1, 16'd0, 16'd1},
      '{DEN_ONE,   32'h8000_0000, 1'b1, 16'd0, 16'd1},
      '{DEN_ONE,   32'h8000_0001, 1'b1, 16'd1, 16'd1},
      '{DEN_ONE,   32'hFFFF_FFFF, 1'b1, 16'd1, 16'd1},
      '{DEN_ZERO,  32'h8000_0001, 1'b1, 16'd1, 16'd1},
      '{DEN_ZERO,  32'h7FFF_FFFF, 1'b1, 16'd0, 16'd1},
      '{16'd2,     32'h5555_5555, 1'b0, 16'd0, 16'd0},
      '{16'd32768, 32'h1234_5678, 1'b0, 16'd0, 16'd0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the first rows run on the reset value of max_den.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].max_den != max_den_shadow) write_max_den(directed_rows[i].max_den);
      given.num = directed_rows[i].num;
      given.den = directed_rows[i].den;
      send_request(directed_rows[i].x, directed_rows[i].typed, given);
    end

    // Random part: one max_den setting and one idling pattern per phase.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0:       phase_den = DEN_TOP;
        1:       phase_den = bra_pkg::MAX_DEN_RESET;
        2:       phase_den = DEN_ONE;
        3:       phase_den = 16'($urandom_range(2, 65535));
        4:       phase_den = DEN_ZERO;
        default: phase_den = 16'($urandom_range(2, 300));
      endcase
      case (ph % 3)
        0:       idle_pct = IDLE_NONE;
        1:       idle_pct = IDLE_SENDER;
        default: idle_pct = IDLE_BOTH;
      endcase
      write_max_den(phase_den);
      given = '0;
      for (int k = 0; k < PHASE_REQS; k++) send_request(pick_fraction(), 1'b0, given);
    end

    // Drain, let the block settle, then count anything still outstanding.
    start <= 1'b0;
    waited = 0;
    while (awaited_fracs.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    fail_count += awaited_fracs.size();

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
